// ===== hw/rtl/spwm_pkg.sv =====
// Shared types, constants and register codes for the three-phase sine PWM block.
package spwm_pkg;

	// default parameter values
	localparam int unsigned DEF_TABLE_DEPTH = 128;
	localparam int unsigned DEF_COUNT_WIDTH = 16;

	// fixed field widths
	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned AGE_W    = 8;
	localparam int unsigned NPHASE   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET    = 3'd4;

	// configuration reset values
	localparam logic [15:0] RST_CARRIER_PERIOD  = 16'd1111;
	localparam logic [7:0]  RST_DEAD_TIME       = 8'd5;
	localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd1500;
	localparam logic [7:0]  RST_TABLE_LENGTH    = 8'd111;
	localparam logic [6:0]  RST_PHASE_OFFSET    = 7'd37;

	// input word command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// one input word as seen by the processing logic, already qualified
	typedef struct packed {
		logic               tick;
		logic               wr;
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] value;
	} item_t;

endpackage

// ===== hw/rtl/spwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spwm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/spwm_lookup.sv =====
// Table index sequencer, wave table copies and shadow compare values.
module spwm_lookup
	import spwm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int unsigned PERIOD_W    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  item_t                           item,
	input  logic                            restart,
	input  logic [15:0]                     carrier_period,
	input  logic [15:0]                     update_interval,
	input  logic [7:0]                      table_length,
	input  logic [6:0]                      phase_offset,
	output logic [NPHASE-1:0][PERIOD_W-1:0] shadow,
	output logic [POS_W-1:0]                sample_position,
	output logic                            busy
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned LEN_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AX_W  = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;
	localparam int unsigned PX_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam logic [2:0]  DIV_STEPS = 3'd7;

	logic [15:0]      ps_q;
	logic [15:0]      ps_inc;
	logic [15:0]      ps_n;
	logic             adv;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_n;
	logic [IDX_W-1:0] idx_new;
	logic [LEN_W:0]   idx_inc;
	logic [LEN_W-1:0] len;
	logic [2:0]       div_left_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   rem_try;
	logic [LEN_W-1:0] rem_n;
	logic [7:0]       po_ext;
	logic [IDX_W-1:0] om;
	logic [LEN_W:0]   sum1;
	logic [LEN_W:0]   red1;
	logic [LEN_W:0]   sum2;
	logic [LEN_W:0]   red2;
	logic [NPHASE-1:0][IDX_W-1:0]    pos;
	logic [NPHASE-1:0][VALUE_W-1:0]  rdata;
	logic [NPHASE-1:0][PERIOD_W-1:0] shadow_q;
	logic [NPHASE-1:0][PERIOD_W-1:0] clamped;
	logic             pending_q;
	logic [PERIOD_W-1:0] half;
	logic [AX_W-1:0]  addr_x;
	logic [IDX_W-1:0] waddr;
	logic             we;
	logic [PX_W-1:0]  pos_x;

	// effective table length: zero acts as one, capped at the depth
	assign len = (table_length == 8'd0) ? LEN_W'(1)
		: ((32'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : LEN_W'(table_length));

	// phase offset reduced modulo the length, restoring, one bit per cycle
	// after reset or a register write; busy while bits remain
	assign po_ext  = {phase_offset, 1'b0};
	assign rem_try = {rem_q, po_ext[div_left_q]};
	assign rem_n   = (rem_try >= {1'b0, len}) ? LEN_W'(rem_try - {1'b0, len})
		: rem_try[LEN_W-1:0];
	assign om      = rem_q[IDX_W-1:0];
	assign busy    = (div_left_q != 3'd0);

	// prescaler and index advance
	always_comb begin
		ps_inc  = ps_q + 16'd1;
		adv     = item.tick && (ps_inc >= update_interval);
		ps_n    = item.tick ? (adv ? 16'd0 : ps_inc) : ps_q;
		idx_inc = (LEN_W + 1)'(idx_q) + (LEN_W + 1)'(1);
		idx_new = (idx_inc >= {1'b0, len}) ? '0 : idx_inc[IDX_W-1:0];
		idx_n   = adv ? idx_new : idx_q;
	end

	// phase read positions, each one compare and subtract from the last
	always_comb begin
		sum1   = (LEN_W + 1)'(idx_new) + (LEN_W + 1)'(om);
		red1   = (sum1 >= {1'b0, len}) ? (sum1 - {1'b0, len}) : sum1;
		sum2   = red1 + (LEN_W + 1)'(om);
		red2   = (sum2 >= {1'b0, len}) ? (sum2 - {1'b0, len}) : sum2;
		pos[0] = idx_new;
		pos[1] = red1[IDX_W-1:0];
		pos[2] = red2[IDX_W-1:0];
	end

	// table write qualification
	assign addr_x = AX_W'(item.addr);
	assign waddr  = addr_x[IDX_W-1:0];
	assign we     = item.wr && (32'(item.addr) < TABLE_DEPTH);

	// one table copy per phase so all three reads happen together
	for (genvar k = 0; k < NPHASE; k++) begin : g_tab
		spwm_ram #(
			.WIDTH(VALUE_W),
			.DEPTH(TABLE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(item.value),
			.re   (adv),
			.raddr(pos[k]),
			.rdata(rdata[k])
		);
	end

	// clamp fresh reads into [0, period/2]
	assign half = carrier_period[PERIOD_W-1:0] >> 1;
	always_comb begin
		for (int k = 0; k < NPHASE; k++) begin
			if (rdata[k][VALUE_W-1]) begin
				clamped[k] = '0;
			end else if (rdata[k] > 16'(half)) begin
				clamped[k] = half;
			end else begin
				clamped[k] = rdata[k][PERIOD_W-1:0];
			end
		end
	end

	// shadow values come straight from the read data in the cycle after an advance
	assign shadow = pending_q ? clamped : shadow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q       <= '0;
			idx_q      <= '0;
			div_left_q <= DIV_STEPS;
			rem_q      <= '0;
			pending_q  <= 1'b0;
			shadow_q   <= '0;
		end else begin
			ps_q      <= ps_n;
			idx_q     <= idx_n;
			pending_q <= adv;
			shadow_q  <= shadow;
			if (restart) begin
				div_left_q <= DIV_STEPS;
				rem_q      <= '0;
			end else if (busy) begin
				div_left_q <= div_left_q - 3'd1;
				rem_q      <= rem_n;
			end
		end
	end

	assign pos_x           = PX_W'(idx_n);
	assign sample_position = pos_x[POS_W-1:0];

endmodule

// ===== hw/rtl/spwm_carrier.sv =====
// Up-down carrier, active compares, raw PWM and dead-time gate logic.
module spwm_carrier
	import spwm_pkg::*;
#(
	parameter int unsigned PERIOD_W = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  logic [PERIOD_W-1:0]             period,
	input  logic [AGE_W-1:0]                dead_time,
	input  logic [NPHASE-1:0][PERIOD_W-1:0] shadow,
	output logic [NPHASE-1:0]               gate_high,
	output logic [NPHASE-1:0]               gate_low,
	output logic [PERIOD_W-1:0]             count
);

	logic [PERIOD_W-1:0] cnt_q;
	logic [PERIOD_W-1:0] cnt_n;
	logic                down_q;
	logic                down_n;
	logic                link_q;
	logic                load;
	logic [NPHASE-1:0][PERIOD_W-1:0] act_q;
	logic [NPHASE-1:0][PERIOD_W-1:0] act_eff;
	logic [NPHASE-1:0]               raw_q;
	logic [NPHASE-1:0]               raw_n;
	logic [NPHASE-1:0][AGE_W-1:0]    age_q;
	logic [NPHASE-1:0][AGE_W-1:0]    age_n;

	// carrier step
	always_comb begin
		cnt_n  = cnt_q;
		down_n = down_q;
		if (tick) begin
			if (!down_q) begin
				if (cnt_q < period) begin
					cnt_n = cnt_q + PERIOD_W'(1);
				end
				if (cnt_n >= period) begin
					down_n = 1'b1;
				end
			end else begin
				if (cnt_q != '0) begin
					cnt_n = cnt_q - PERIOD_W'(1);
				end
				if (cnt_n == '0) begin
					down_n = 1'b0;
				end
			end
		end
		load = tick && ((cnt_n == '0) || (cnt_n == period));
	end

	// active compare follows the shadow in the cycle after a load
	assign act_eff = link_q ? shadow : act_q;

	// compare match, edge age and gates
	always_comb begin
		for (int k = 0; k < NPHASE; k++) begin
			raw_n[k] = raw_q[k];
			age_n[k] = age_q[k];
			if (tick) begin
				if (cnt_n == act_eff[k]) begin
					raw_n[k] = !down_q;
				end
				if (raw_n[k] != raw_q[k]) begin
					age_n[k] = '0;
				end else if (age_q[k] != AGE_MAX) begin
					age_n[k] = age_q[k] + AGE_W'(1);
				end
			end
			gate_high[k] = raw_n[k] && (age_n[k] >= dead_time);
			gate_low[k]  = !raw_n[k] && (age_n[k] >= dead_time);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			down_q <= 1'b0;
			link_q <= 1'b0;
			act_q  <= '0;
			raw_q  <= '0;
			age_q  <= '0;
		end else begin
			cnt_q  <= cnt_n;
			down_q <= down_n;
			link_q <= load;
			act_q  <= act_eff;
			raw_q  <= raw_n;
			age_q  <= age_n;
		end
	end

	assign count = cnt_n;

endmodule

// ===== hw/rtl/three_phase_spwm_dead_time_unit.sv =====
// Top level of the three-phase sine PWM block with complementary gates and dead time.
//
// Input stream (s_*): each word is either a timer tick (tuser cmd 0) or a
// wave table write (tuser cmd 1, address and signed value in tdata). Every
// input word yields exactly one result word on the output stream (m_*): the
// six gate levels, the carrier count and the table index after that word.
// Configuration (cfg_*): index plus data, always ready; the user must write it only
// while idle, which the block does not enforce. A taken word is held in the input
// register and worked through when it fires; its result lands in the output register.
// Throughput: one word per cycle while the receiver is ready and no offset reduction
// runs; the three phase reads come from three copies of the wave table, each read
// once per index advance. After reset and after each configuration write the phase
// offset is reduced modulo the table length; a word waits in the input register.
// When the receiver stalls, the result stays in the output register and one
// more word can wait in the input register; s_tready drops after that.
// Reset: registers take their default values, counters, compares and edge
// ages clear, the table keeps no defined content until it is written.
module three_phase_spwm_dead_time_unit
	import spwm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // table_address[6:0], table_value[22:7]
	input  logic [0:0]            s_tuser,   // cmd[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // u_high, u_low, v_high, v_low, w_high,
	                                         // w_low [5:0], carrier_value[21:6],
	                                         // sample_position[28:22]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned PERIOD_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

	logic [15:0]         carrier_period_q;
	logic [7:0]          dead_time_q;
	logic [15:0]         update_interval_q;
	logic [7:0]          table_length_q;
	logic [6:0]          phase_offset_q;

	logic                valid_s1;
	logic                cmd_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic                s_acc;
	logic                fire;
	logic                cfg_wr;
	logic                lookup_busy;
	item_t               item;

	logic [NPHASE-1:0][PERIOD_W-1:0] shadow;
	logic [NPHASE-1:0]   gate_high;
	logic [NPHASE-1:0]   gate_low;
	logic [PERIOD_W-1:0] count;
	logic [POS_W-1:0]    sample_position;
	logic [31:0]         result;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_period_q  <= RST_CARRIER_PERIOD;
			dead_time_q       <= RST_DEAD_TIME;
			update_interval_q <= RST_UPDATE_INTERVAL;
			table_length_q    <= RST_TABLE_LENGTH;
			phase_offset_q    <= RST_PHASE_OFFSET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_CARRIER_PERIOD:  carrier_period_q  <= cfg_data;
				CFG_DEAD_TIME:       dead_time_q       <= cfg_data[7:0];
				CFG_UPDATE_INTERVAL: update_interval_q <= cfg_data;
				CFG_TABLE_LENGTH:    table_length_q    <= cfg_data[7:0];
				CFG_PHASE_OFFSET:    phase_offset_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register; the word is worked when the output slot is free and the lookup is not busy
	assign fire     = valid_s1 && !lookup_busy && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1   <= s_tuser[0];
			addr_s1  <= s_tdata[6:0];
			value_s1 <= s_tdata[22:7];
		end
	end

	// qualified word for the processing logic
	always_comb begin
		item.tick  = fire && (cmd_s1 == CMD_TICK);
		item.wr    = fire && (cmd_s1 == CMD_WRITE);
		item.addr  = addr_s1;
		item.value = value_s1;
	end

	spwm_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PERIOD_W   (PERIOD_W)
	) u_lookup (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.restart        (cfg_wr),
		.carrier_period (carrier_period_q),
		.update_interval(update_interval_q),
		.table_length   (table_length_q),
		.phase_offset   (phase_offset_q),
		.shadow         (shadow),
		.sample_position(sample_position),
		.busy           (lookup_busy)
	);

	spwm_carrier #(
		.PERIOD_W(PERIOD_W)
	) u_carrier (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (item.tick),
		.period   (carrier_period_q[PERIOD_W-1:0]),
		.dead_time(dead_time_q),
		.shadow   (shadow),
		.gate_high(gate_high),
		.gate_low (gate_low),
		.count    (count)
	);

	// result word packing
	assign result = {3'b000, sample_position, 16'(count),
		gate_low[2], gate_high[2], gate_low[1], gate_high[1], gate_low[0], gate_high[0]};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= result;
		end
	end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the three-phase sine PWM block with dead time.
module tb;
	import spwm_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam int WAVE_DEPTH  = 128;

	// one result word as it sits in m_tdata[28:0]
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [15:0]      carrier;
		logic [5:0]       gates;   // u_high, u_low, v_high, v_low, w_high, w_low from bit 0
	} gate_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;   // table_address[6:0], table_value[22:7]
	logic [0:0]            s_tuser = '0;   // cmd[0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;        // gates[5:0], carrier_value[21:6], sample_position[28:22]
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	three_phase_spwm_dead_time_unit uut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [15:0] wave_mem [WAVE_DEPTH];
	logic [15:0] carrier_cnt = '0;
	logic        carrier_down = 1'b0;
	logic [15:0] prescale_cnt = '0;
	logic [6:0]  sample_idx = '0;
	logic [15:0] shadow_cmp [NPHASE] = '{default: '0};
	logic [15:0] active_cmp [NPHASE] = '{default: '0};
	logic        raw_gate [NPHASE] = '{default: 1'b0};
	logic [7:0]  edge_age [NPHASE] = '{default: '0};

	// register copies
	logic [15:0] reg_period   = RST_CARRIER_PERIOD;
	logic [7:0]  reg_dead     = RST_DEAD_TIME;
	logic [15:0] reg_interval = RST_UPDATE_INTERVAL;
	logic [7:0]  reg_length   = RST_TABLE_LENGTH;
	logic [6:0]  reg_offset   = RST_PHASE_OFFSET;

	gate_word_t gate_words_due [$];
	string      gate_names [6] = '{"u_high", "u_low", "v_high", "v_low", "w_high", "w_low"};
	int         mismatches = 0;
	int         words_checked = 0;
	int         cycles = 0;
	int         stall_request = 0;
	int         stall_left = 0;
	bit         src_steady = 1'b0;
	bit         sink_steady = 1'b0;

	// advance the predicted block by one input word and return the gate word it shows
	function automatic gate_word_t next_gate_word(input logic cmd, input logic [6:0] addr,
	                                              input logic [15:0] value);
		gate_word_t w;
		logic       was_down;
		logic       old_raw;
		logic       settled;
		int         len;
		int         half;
		int         entry;
		if (cmd == CMD_WRITE) begin
			wave_mem[addr] = value;
		end else begin
			was_down = carrier_down;
			// prescaler and table index first
			prescale_cnt = prescale_cnt + 1'b1;
			if (prescale_cnt >= reg_interval) begin
				prescale_cnt = '0;
				len = reg_length;
				if (len == 0) len = 1;
				if (len > WAVE_DEPTH) len = WAVE_DEPTH;
				sample_idx = (sample_idx + 1 >= len) ? 7'd0 : sample_idx + 1'b1;
				half = reg_period / 2;
				for (int k = 0; k < NPHASE; k++) begin
					entry = $signed(wave_mem[(sample_idx + k * reg_offset) % len]);
					if (entry < 0) entry = 0;
					if (entry > half) entry = half;
					shadow_cmp[k] = entry[15:0];
				end
			end
			// up-down carrier
			if (!was_down) begin
				if (carrier_cnt < reg_period) carrier_cnt = carrier_cnt + 1'b1;
				if (carrier_cnt >= reg_period) carrier_down = 1'b1;
			end else begin
				if (carrier_cnt > 0) carrier_cnt = carrier_cnt - 1'b1;
				if (carrier_cnt == 0) carrier_down = 1'b0;
			end
			// compare match against the compares in force before this tick
			for (int k = 0; k < NPHASE; k++) begin
				old_raw = raw_gate[k];
				if (carrier_cnt == active_cmp[k]) raw_gate[k] = !was_down;
				if (raw_gate[k] != old_raw) edge_age[k] = '0;
				else if (edge_age[k] != AGE_MAX) edge_age[k] = edge_age[k] + 1'b1;
			end
			if (carrier_cnt == 0 || carrier_cnt == reg_period) begin
				for (int k = 0; k < NPHASE; k++) active_cmp[k] = shadow_cmp[k];
			end
		end
		for (int k = 0; k < NPHASE; k++) begin
			settled = edge_age[k] >= reg_dead;
			w.gates[2 * k]     = raw_gate[k] && settled;
			w.gates[2 * k + 1] = !raw_gate[k] && settled;
		end
		w.carrier  = carrier_cnt;
		w.position = sample_idx;
		return w;
	endfunction

	// table entry: mostly usable duty values, some negative, some above half period
	function automatic logic [15:0] wave_entry();
		case ($urandom_range(9))
			0: return 16'h8000 | 16'($urandom);
			1: return 16'($urandom_range(32767, 100));
			default: return 16'($urandom_range(90));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 20) $display("mismatch at result %0d: %s", words_checked, what);
	endtask

	// offer one word, wait for it to be taken, then record its expected result
	task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
	                         input logic [VALUE_W-1:0] value);
		while (!src_steady && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, value, addr};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		gate_words_due.push_back(next_gate_word(cmd, addr, value));
	endtask

	// stop offering and wait until every expected word has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (gate_words_due.size() != 0) @(posedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes; set_registers lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CARRIER_PERIOD:  reg_period   = data;
			CFG_DEAD_TIME:       reg_dead     = data[7:0];
			CFG_UPDATE_INTERVAL: reg_interval = data;
			CFG_TABLE_LENGTH:    reg_length   = data[7:0];
			CFG_PHASE_OFFSET:    reg_offset   = data[6:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [15:0] period, input logic [7:0] dead,
	                             input logic [15:0] interval, input logic [7:0] length,
	                             input logic [6:0] offset);
		wait_idle();
		write_reg(CFG_CARRIER_PERIOD, period);
		write_reg(CFG_DEAD_TIME, 16'(dead));
		write_reg(CFG_UPDATE_INTERVAL, interval);
		write_reg(CFG_TABLE_LENGTH, 16'(length));
		write_reg(CFG_PHASE_OFFSET, 16'(offset));
		cfg_valid <= 1'b0;
	endtask

	// random setting, mostly short carrier cycles and fast table updates
	task automatic pick_settings();
		logic [15:0] period;
		logic [7:0]  dead;
		logic [15:0] interval;
		logic [7:0]  length;
		period   = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 2))
		                                    : 16'($urandom_range(160, 2));
		dead     = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
		interval = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 1))
		                                    : 16'($urandom_range(24, 1));
		length   = 8'($urandom_range(128, 3));
		set_registers(period, dead, interval, length, 7'($urandom_range(length - 1)));
	endtask

	// mostly ticks with junk payload, some table rewrites
	task automatic run_words(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 8)
				send_word(CMD_WRITE, 7'($urandom_range(127)), wave_entry());
			else
				send_word(CMD_TICK, 7'($urandom), 16'($urandom));
		end
	endtask

	// a few ticks under the reset register values, before the table is read
	task automatic test_reset_values();
		send_word(CMD_TICK, 7'h7f, 16'hffff);
		send_word(CMD_TICK, 7'h00, 16'h0000);
		send_word(CMD_TICK, 7'h55, 16'haaaa);
	endtask

	// fill every table entry so no advance ever reads an unwritten one
	task automatic test_table_load();
		for (int a = 0; a < WAVE_DEPTH; a++) begin
			if (a == 0) send_word(CMD_WRITE, 7'(a), 16'h8000);
			else if (a == WAVE_DEPTH - 1) send_word(CMD_WRITE, 7'(a), 16'h7fff);
			else send_word(CMD_WRITE, 7'(a), wave_entry());
		end
	endtask

	task automatic test_corner_settings();
		// zero update interval and zero table length: advance every tick on one point
		set_registers(16'd2, 8'd0, 16'd0, 8'd0, 7'd0);
		repeat (5) send_word(CMD_TICK, 7'($urandom), 16'($urandom));
		// zero carrier period, table length above the depth
		set_registers(16'd0, 8'd1, 16'd1, 8'd200, 7'd127);
		repeat (3) send_word(CMD_TICK, 7'($urandom), 16'($urandom));
		set_registers(16'd12, 8'd2, 16'd1, 8'd7, 7'd3);
		repeat (8) send_word(CMD_TICK, 7'($urandom), 16'($urandom));
		// carrier above the new period, index beyond the new length
		set_registers(16'd3, 8'd0, 16'd1, 8'd3, 7'd1);
		repeat (4) send_word(CMD_TICK, 7'($urandom), 16'($urandom));
		// all registers at their top values, the table length at the depth
		set_registers(16'd65535, 8'd255, 16'd65535, 8'd128, 7'd127);
		repeat (3) send_word(CMD_TICK, 7'($urandom), 16'($urandom));
	endtask

	task automatic test_random_traffic();
		repeat (5) begin
			pick_settings();
			run_words(260);
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_back_pressure();
		pick_settings();
		src_steady = 1'b1;
		stall_request = 64;
		run_words(200);
		src_steady = 1'b0;
	endtask

	task automatic test_steady_stream();
		pick_settings();
		src_steady = 1'b1;
		sink_steady = 1'b1;
		run_words(250);
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// receiver ready, with random stalls and a commanded hold-off
	always @(posedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= sink_steady || $urandom_range(99) >= 17;
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		gate_word_t got;
		gate_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[28:0];
			if (gate_words_due.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing expected", m_tdata));
			end else begin
				want = gate_words_due.pop_front();
				for (int g = 0; g < 6; g++) begin
					if (got.gates[g] !== want.gates[g])
						report_mismatch($sformatf("%s is %b, expected %b",
							gate_names[g], got.gates[g], want.gates[g]));
				end
				if (got.carrier !== want.carrier)
					report_mismatch($sformatf("carrier_value is %0d, expected %0d",
						got.carrier, want.carrier));
				if (got.position !== want.position)
					report_mismatch($sformatf("sample_position is %0d, expected %0d",
						got.position, want.position));
			end
			words_checked++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_table_load();
		test_corner_settings();
		test_random_traffic();
		test_back_pressure();
		test_steady_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
